>>> rtl/core/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg: shared types, constants and trig tables of the grid ray marcher
// Holds the beat formats, the sequencer states, the Q1.14 sine and cosine
// quadrant tables (built at elaboration) and the small divide helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package grm_pkg;

	localparam int MAP_SIDE    = 16;
	localparam int STEP_COUNT  = 380;
	localparam int ANGLE_STEPS = 720;

	localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
	localparam int MAP_AW    = $clog2(MAP_CELLS);
	localparam int K_W       = $clog2(STEP_COUNT + 1);
	localparam int LAST_K    = STEP_COUNT - 1;

	localparam logic [7:0] SPACE_CODE = 8'd32;

	localparam int DIST_DEN  = 20;
	localparam int POS_MUL   = 80;
	localparam int CELL_UNIT = 327680;
	localparam int CELL_DIV  = CELL_UNIT / 65536;
	localparam int TEX_WIDTH = 65;
	localparam int TEX_MUL   = TEX_WIDTH * 65536 / CELL_UNIT;

	localparam int Q_W        = 10;
	localparam int COL_W      = Q_W - 2;
	localparam int XS_W       = Q_W + 17;
	localparam int FRAC_W     = 19;
	localparam int DIV5_MUL   = 205;
	localparam int DIV5_SHIFT = 10;

	localparam logic signed [XS_W-1:0] MAP_LIMIT = XS_W'(MAP_SIDE * CELL_UNIT);

	localparam int ANGLE_IN_W  = 10;
	localparam int ANGLE_WRAPS = (2 ** ANGLE_IN_W - 1) / ANGLE_STEPS;
	localparam int AMOD_W      = 13;
	localparam int ANG_W       = $clog2(ANGLE_STEPS);
	localparam int QUAD_STEPS  = ANGLE_STEPS / 4;
	localparam int QI_W        = $clog2(QUAD_STEPS);
	localparam int TRIG_W      = 15;
	localparam int TRIG_ONE    = 16384;
	localparam int TRIG_LAT    = 3;
	localparam int CNT_W       = $clog2(TRIG_LAT);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_CAST  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_WALL  = 2'd0,
		ST_NONE  = 2'd1,
		ST_LEFT  = 2'd2,
		ST_WRITE = 2'd3
	} status_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [7:0]  cell_index;
		logic [7:0]  cell_code;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [9:0]  ray_angle;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [8:0] step_index;
		logic [7:0] hit_code;
		logic [6:0] texture_column;
	} res_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_TRIG,
		FSM_INIT,
		FSM_MARCH,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic signed [15:0] sn;
		logic signed [15:0] cs;
	} trig_t;

	typedef struct packed {
		logic init;
		logic adv;
	} step_ctl_t;

	typedef struct packed {
		logic              oob;
		logic [MAP_AW-1:0] addr;
		logic [K_W-1:0]    k;
		logic [FRAC_W-1:0] frac;
	} point_t;

	typedef struct packed {
		logic              en;
		logic [MAP_AW-1:0] addr;
		logic [7:0]        data;
	} map_wr_t;

	typedef logic [TRIG_W-1:0] trig_tab_t [QUAD_STEPS];

	// floor(v / 5) for any Q_W-bit value
	function automatic logic [COL_W-1:0] div5(input logic [Q_W-1:0] v);
		logic [Q_W+7:0] p;
		p = (Q_W + 8)'(v) * (Q_W + 8)'(DIV5_MUL);
		return p[Q_W+7:DIV5_SHIFT];
	endfunction

	function automatic logic [63:0] sin_div(input logic [63:0] t, input int n);
		logic [63:0] r;
		case (n)
			1:       r = t / 64'd6;
			2:       r = t / 64'd20;
			3:       r = t / 64'd42;
			4:       r = t / 64'd72;
			5:       r = t / 64'd110;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] cos_div(input logic [63:0] t, input int n);
		logic [63:0] r;
		case (n)
			1:       r = t / 64'd2;
			2:       r = t / 64'd12;
			3:       r = t / 64'd30;
			4:       r = t / 64'd56;
			5:       r = t / 64'd90;
			6:       r = t / 64'd132;
			default: r = '0;
		endcase
		return r;
	endfunction

	// taylor series per quadrant step, rounded to q1.14
	function automatic trig_tab_t build_trig(input logic want_cos);
		trig_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		int          i;
		int          n;
		for (i = 0; i < QUAD_STEPS; i++) begin
			x  = (64'(4 * i) * HALF_PI_Q30) / 64'(ANGLE_STEPS);
			x2 = (x * x) >> 30;
			if (want_cos) begin
				term = 64'd1 << 30;
				sum  = longint'(term);
				for (n = 1; n <= 6; n++) begin
					term = cos_div((term * x2) >> 30, n);
					if (n % 2 == 1) sum = sum - longint'(term);
					else sum = sum + longint'(term);
				end
			end else begin
				term = x;
				sum  = longint'(term);
				for (n = 1; n <= 5; n++) begin
					term = sin_div((term * x2) >> 30, n);
					if (n % 2 == 1) sum = sum - longint'(term);
					else sum = sum + longint'(term);
				end
			end
			if (sum < 0) sum = 0;
			tab[i] = TRIG_W'((sum + 32768) >>> 16);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_trig(1'b0);
	localparam trig_tab_t COS_TAB = build_trig(1'b1);

endpackage

`default_nettype wire

>>> rtl/core/grm_map.sv
// ----------------------------------------------------------------------------
// grm_map: map store of cell codes
// One write port, one registered read port. Per-entry valid bits make an
// entry that was never written read back as a space.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_map (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire grm_pkg::map_wr_t          wr,
	input  wire logic [grm_pkg::MAP_AW-1:0] raddr,
	output logic [7:0]                     rdata
);

	logic [7:0]                    mem_q [grm_pkg::MAP_CELLS];
	logic [grm_pkg::MAP_CELLS-1:0] vld_q;
	logic [7:0]                    rdata_q;
	logic                          rvld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : grm_pkg::SPACE_CODE;

endmodule

`default_nettype wire

>>> rtl/core/grm_trig.sv
// ----------------------------------------------------------------------------
// grm_trig: ray angle to q1.14 sine and cosine
// Three stages: angle wrap, quadrant split, table lookup with quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_trig (
	input  wire logic       clk,
	input  wire logic [9:0] angle,
	output grm_pkg::trig_t  trig
);

	logic [grm_pkg::AMOD_W-1:0] a_wide;
	logic [grm_pkg::ANG_W-1:0]  a_s1;
	logic [1:0]                 quad;
	logic [grm_pkg::ANG_W-1:0]  base;
	logic [1:0]                 quad_s2;
	logic [grm_pkg::QI_W-1:0]   idx_s2;
	logic signed [15:0]         s0;
	logic signed [15:0]         c0;
	grm_pkg::trig_t             trig_d;
	grm_pkg::trig_t             trig_s3;

	always_comb begin
		a_wide = grm_pkg::AMOD_W'(angle);
		for (int i = 0; i < grm_pkg::ANGLE_WRAPS; i++) begin
			if (a_wide >= grm_pkg::AMOD_W'(grm_pkg::ANGLE_STEPS)) begin
				a_wide = a_wide - grm_pkg::AMOD_W'(grm_pkg::ANGLE_STEPS);
			end
		end
	end

	always_comb begin
		if (a_s1 >= grm_pkg::ANG_W'(3 * grm_pkg::QUAD_STEPS)) begin
			quad = 2'd3;
			base = grm_pkg::ANG_W'(3 * grm_pkg::QUAD_STEPS);
		end else if (a_s1 >= grm_pkg::ANG_W'(2 * grm_pkg::QUAD_STEPS)) begin
			quad = 2'd2;
			base = grm_pkg::ANG_W'(2 * grm_pkg::QUAD_STEPS);
		end else if (a_s1 >= grm_pkg::ANG_W'(grm_pkg::QUAD_STEPS)) begin
			quad = 2'd1;
			base = grm_pkg::ANG_W'(grm_pkg::QUAD_STEPS);
		end else begin
			quad = 2'd0;
			base = '0;
		end
	end

	always_comb begin
		s0 = $signed({1'b0, grm_pkg::SIN_TAB[idx_s2]});
		c0 = $signed({1'b0, grm_pkg::COS_TAB[idx_s2]});
		unique case (quad_s2)
			2'd0: begin
				trig_d.sn = s0;
				trig_d.cs = c0;
			end
			2'd1: begin
				trig_d.sn = c0;
				trig_d.cs = -s0;
			end
			2'd2: begin
				trig_d.sn = -s0;
				trig_d.cs = -c0;
			end
			default: begin
				trig_d.sn = -c0;
				trig_d.cs = s0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		a_s1    <= grm_pkg::ANG_W'(a_wide);
		quad_s2 <= quad;
		idx_s2  <= grm_pkg::QI_W'(a_s1 - base);
		trig_s3 <= trig_d;
	end

	assign trig = trig_s3;

endmodule

`default_nettype wire

>>> rtl/core/grm_step.sv
// ----------------------------------------------------------------------------
// grm_step: shared march step unit
// Holds the current sample point, advances it by one direction vector per
// step and decodes it into bounds status, map address and x fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_step (
	input  wire logic              clk,
	input  wire grm_pkg::step_ctl_t ctl,
	input  wire logic [15:0]       pos_x,
	input  wire logic [15:0]       pos_y,
	input  wire grm_pkg::trig_t    trig,
	output grm_pkg::point_t        pt
);

	logic signed [grm_pkg::XS_W-1:0] xs_q;
	logic signed [grm_pkg::XS_W-1:0] ys_q;
	logic [grm_pkg::K_W-1:0]         k_q;
	logic signed [grm_pkg::XS_W-1:0] csx;
	logic signed [grm_pkg::XS_W-1:0] snx;
	logic signed [grm_pkg::XS_W-1:0] x0;
	logic signed [grm_pkg::XS_W-1:0] y0;
	logic [grm_pkg::Q_W-1:0]         xq;
	logic [grm_pkg::Q_W-1:0]         yq;
	logic [grm_pkg::COL_W-1:0]       colx;
	logic [grm_pkg::COL_W-1:0]       rowy;
	logic [grm_pkg::Q_W-1:0]         rem_x;

	always_comb begin
		csx = grm_pkg::XS_W'(trig.cs);
		snx = grm_pkg::XS_W'(trig.sn);
		x0  = grm_pkg::XS_W'(pos_x) * grm_pkg::XS_W'(grm_pkg::POS_MUL)
			+ csx * grm_pkg::XS_W'(grm_pkg::DIST_DEN);
		y0  = grm_pkg::XS_W'(pos_y) * grm_pkg::XS_W'(grm_pkg::POS_MUL)
			+ snx * grm_pkg::XS_W'(grm_pkg::DIST_DEN);
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			xs_q <= x0;
			ys_q <= y0;
			k_q  <= '0;
		end else if (ctl.adv) begin
			xs_q <= xs_q + csx;
			ys_q <= ys_q + snx;
			k_q  <= k_q + 1'b1;
		end
	end

	always_comb begin
		xq    = xs_q[grm_pkg::XS_W-2:16];
		yq    = ys_q[grm_pkg::XS_W-2:16];
		colx  = grm_pkg::div5(xq);
		rowy  = grm_pkg::div5(yq);
		rem_x = xq - grm_pkg::Q_W'(colx) * grm_pkg::Q_W'(grm_pkg::CELL_DIV);

		pt.oob  = xs_q[grm_pkg::XS_W-1] | ys_q[grm_pkg::XS_W-1]
			| (xs_q >= grm_pkg::MAP_LIMIT) | (ys_q >= grm_pkg::MAP_LIMIT);
		pt.addr = grm_pkg::MAP_AW'(rowy) * grm_pkg::MAP_AW'(grm_pkg::MAP_SIDE)
			+ grm_pkg::MAP_AW'(colx);
		pt.k    = k_q;
		pt.frac = {rem_x[2:0], xs_q[15:0]};
	end

endmodule

`default_nettype wire

>>> rtl/core/grid_ray_march_top.sv
// ----------------------------------------------------------------------------
// grid_ray_march_top: fixed-step ray marcher over a grid map of cell codes
// Write beats store one map cell; cast beats march one ray and report the
// first non-space cell, leaving the map, or no wall in range.
// ----------------------------------------------------------------------------
// write beat: result registered in the done state once the output is not stalled
// cast beat stopping at step k: trig, init and march states, then done, with
//   one map read per step through the shared step unit
// a beat of either kind holds the input side until the sequencer is back in idle
// reset clears the sequencer and the map valid bits: every cell reads as
//   a space right after reset, no clearing pass
`default_nettype none

module grid_ray_march_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire grm_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_stall,
	output grm_pkg::res_t      res
);

	grm_pkg::fsm_t              state_q;
	grm_pkg::fsm_t              state_d;
	logic [grm_pkg::CNT_W-1:0]  cnt_q;
	logic [9:0]                 ang_q;
	logic [15:0]                posx_q;
	logic [15:0]                posy_q;
	grm_pkg::res_t              pend_q;
	grm_pkg::res_t              res_q;
	logic                       res_valid_q;
	logic                       vld_s1;
	grm_pkg::point_t            pt_s1;

	grm_pkg::trig_t             trig;
	grm_pkg::point_t            pt;
	grm_pkg::step_ctl_t         step_ctl;
	grm_pkg::map_wr_t           map_wr;
	logic [7:0]                 code;
	grm_pkg::res_t              fin;
	logic [22:0]                tex_prod;
	logic                       accept;
	logic                       is_write;
	logic                       stop_left;
	logic                       stop_hit;
	logic                       stop_none;
	logic                       stop;
	logic                       issue;
	logic                       res_load;

	grm_trig u_trig (
		.clk   (clk),
		.angle (ang_q),
		.trig  (trig)
	);

	grm_step u_step (
		.clk   (clk),
		.ctl   (step_ctl),
		.pos_x (posx_q),
		.pos_y (posy_q),
		.trig  (trig),
		.pt    (pt)
	);

	grm_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (map_wr),
		.raddr  (pt.addr),
		.rdata  (code)
	);

	always_comb begin
		req_stall = (state_q != grm_pkg::FSM_IDLE);
		accept    = req_valid && !req_stall;
		is_write  = (req.req_type == grm_pkg::REQ_WRITE);

		stop_left = vld_s1 && pt_s1.oob;
		stop_hit  = vld_s1 && !pt_s1.oob && (code != grm_pkg::SPACE_CODE);
		stop_none = vld_s1 && !pt_s1.oob && (code == grm_pkg::SPACE_CODE)
			&& (pt_s1.k == grm_pkg::K_W'(grm_pkg::LAST_K));
		stop      = stop_left || stop_hit || stop_none;
		issue     = (state_q == grm_pkg::FSM_MARCH) && !stop
			&& (pt.k < grm_pkg::K_W'(grm_pkg::STEP_COUNT));

		step_ctl.init = (state_q == grm_pkg::FSM_INIT);
		step_ctl.adv  = issue;

		map_wr.en   = accept && is_write
			&& (32'(req.cell_index) < 32'(grm_pkg::MAP_CELLS));
		map_wr.addr = grm_pkg::MAP_AW'(req.cell_index);
		map_wr.data = req.cell_code;

		tex_prod = 23'(pt_s1.frac) * 23'(grm_pkg::TEX_MUL);

		fin = '0;
		if (state_q == grm_pkg::FSM_IDLE) begin
			fin.status = grm_pkg::ST_WRITE;
		end else if (stop_left) begin
			fin.status     = grm_pkg::ST_LEFT;
			fin.step_index = 9'(pt_s1.k);
		end else if (stop_hit) begin
			fin.status         = grm_pkg::ST_WALL;
			fin.step_index     = 9'(pt_s1.k);
			fin.hit_code       = code;
			fin.texture_column = tex_prod[22:16];
		end else begin
			fin.status = grm_pkg::ST_NONE;
		end

		res_load  = (state_q == grm_pkg::FSM_DONE) && (!res_valid_q || !res_stall);
		res_valid = res_valid_q;
		res       = res_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grm_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = is_write ? grm_pkg::FSM_DONE : grm_pkg::FSM_TRIG;
				end
			end
			grm_pkg::FSM_TRIG: begin
				if (cnt_q == grm_pkg::CNT_W'(grm_pkg::TRIG_LAT - 1)) begin
					state_d = grm_pkg::FSM_INIT;
				end
			end
			grm_pkg::FSM_INIT: begin
				state_d = grm_pkg::FSM_MARCH;
			end
			grm_pkg::FSM_MARCH: begin
				if (stop) begin
					state_d = grm_pkg::FSM_DONE;
				end
			end
			grm_pkg::FSM_DONE: begin
				if (res_load) begin
					state_d = grm_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = grm_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grm_pkg::FSM_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == grm_pkg::FSM_TRIG) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ang_q  <= req.ray_angle;
			posx_q <= req.pos_x;
			posy_q <= req.pos_y;
		end
		if ((accept && is_write) || ((state_q == grm_pkg::FSM_MARCH) && stop)) begin
			pend_q <= fin;
		end
		if (res_load) begin
			res_q <= pend_q;
		end
		pt_s1 <= pt;
	end

	// march pipeline only carries points while marching
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == grm_pkg::FSM_MARCH))
		else $error("march point in flight outside the march state");

	// consecutive points in flight are consecutive steps
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && $past(vld_s1) |-> (pt_s1.k == grm_pkg::K_W'($past(pt_s1.k) + 1'b1)))
		else $error("march step skipped or repeated");

	// direction vector components are each within one at march start
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == grm_pkg::FSM_INIT) |->
			(trig.cs <= 16'sd16384) && (trig.cs >= -16'sd16384)
			&& (trig.sn <= 16'sd16384) && (trig.sn >= -16'sd16384))
		else $error("trig value out of q1.14 range");

	// a write beat always answers with write done
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_write |=>
			(state_q == grm_pkg::FSM_DONE) && (pend_q.status == grm_pkg::ST_WRITE))
		else $error("write beat without write done result");

	// a new result only comes out of the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == grm_pkg::FSM_DONE))
		else $error("result raised outside the done state");

endmodule

`default_nettype wire

>>> dv/tb_grid_ray_march_top.sv
// ----------------------------------------------------------------------------
// tb_grid_ray_march_top: self-checking testbench of the grid ray marcher
// Drives write and cast beats with random gaps and random result stalls. A
// built-in map copy and fixed-point marcher predict every result, and each
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_grid_ray_march_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     POS_SCALE   = 80;
	localparam int     DIST_BASE   = 20;
	localparam longint CELL_FIXED  = 327680;
	localparam longint TEX_SPAN    = 65;
	localparam int     IDLE_LIMIT  = 4000;
	localparam int     DRAIN_WAIT  = 400;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	grm_pkg::req_t req       = '0;
	logic          res_valid;
	logic          res_stall = 1'b0;
	grm_pkg::res_t res;

	logic [7:0]    map_model [grm_pkg::MAP_CELLS];
	grm_pkg::res_t pending_results [$];
	int            fail_count     = 0;
	int            stall_left     = 0;
	int            quiet_cycles   = 0;
	bit            tx_idle_on     = 1'b1;
	bit            rx_idle_on     = 1'b1;

	grid_ray_march_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint round_q14(input longint v);
		if (v < 0) v = 0;
		return (v + 32768) >>> 16;
	endfunction

	function automatic void sin_cos_q14(input logic [9:0] ang, output longint sn,
		output longint cs);
		longint unsigned a;
		longint unsigned q;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint          s0;
		longint          c0;
		int              n;
		a  = 64'(ang) % 64'(grm_pkg::ANGLE_STEPS);
		a  = a * 4;
		q  = a / 64'(grm_pkg::ANGLE_STEPS);
		r  = a - q * 64'(grm_pkg::ANGLE_STEPS);
		x  = r * 64'd1686629713 / 64'(grm_pkg::ANGLE_STEPS);
		x2 = (x * x) >> 30;
		term = x;
		acc  = longint'(term);
		for (n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		s0 = round_q14(acc);
		term = 64'd1 << 30;
		acc  = longint'(term);
		for (n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		c0 = round_q14(acc);
		case (q)
			0: begin
				sn = s0;
				cs = c0;
			end
			1: begin
				sn = c0;
				cs = -s0;
			end
			2: begin
				sn = -s0;
				cs = -c0;
			end
			default: begin
				sn = -c0;
				cs = s0;
			end
		endcase
	endfunction

	// applies one beat to the map copy and returns the result it causes
	function automatic grm_pkg::res_t march_result(input grm_pkg::req_t b);
		grm_pkg::res_t r;
		longint        sn;
		longint        cs;
		longint        xs;
		longint        ys;
		longint        col;
		longint        row;
		int            k;
		r = '0;
		if (b.req_type == grm_pkg::REQ_WRITE) begin
			if (b.cell_index < grm_pkg::MAP_CELLS) map_model[b.cell_index] = b.cell_code;
			r.status = grm_pkg::ST_WRITE;
			return r;
		end
		sin_cos_q14(b.ray_angle, sn, cs);
		for (k = 0; k < grm_pkg::STEP_COUNT; k++) begin
			xs = longint'(b.pos_x) * POS_SCALE + longint'(DIST_BASE + k) * cs;
			ys = longint'(b.pos_y) * POS_SCALE + longint'(DIST_BASE + k) * sn;
			col = xs / CELL_FIXED;
			row = ys / CELL_FIXED;
			if (xs < 0 || ys < 0 || col >= grm_pkg::MAP_SIDE || row >= grm_pkg::MAP_SIDE) begin
				r.status     = grm_pkg::ST_LEFT;
				r.step_index = 9'(k);
				return r;
			end
			if (map_model[row * grm_pkg::MAP_SIDE + col] != grm_pkg::SPACE_CODE) begin
				r.status         = grm_pkg::ST_WALL;
				r.step_index     = 9'(k);
				r.hit_code       = map_model[row * grm_pkg::MAP_SIDE + col];
				r.texture_column = 7'(((xs % CELL_FIXED) * TEX_SPAN) / CELL_FIXED);
				return r;
			end
		end
		r.status = grm_pkg::ST_NONE;
		return r;
	endfunction

	function automatic grm_pkg::req_t write_beat(input int idx, input int code);
		grm_pkg::req_t b;
		b            = grm_pkg::req_t'({$urandom, $urandom});
		b.req_type   = grm_pkg::REQ_WRITE;
		b.cell_index = 8'(idx);
		b.cell_code  = 8'(code);
		return b;
	endfunction

	function automatic grm_pkg::req_t cast_beat(input int px, input int py, input int ang);
		grm_pkg::req_t b;
		b           = grm_pkg::req_t'({$urandom, $urandom});
		b.req_type  = grm_pkg::REQ_CAST;
		b.pos_x     = 16'(px);
		b.pos_y     = 16'(py);
		b.ray_angle = 10'(ang);
		return b;
	endfunction

	function automatic int pick_gap();
		int p;
		if (!tx_idle_on) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic int wall_code();
		int c;
		c = $urandom_range(0, 255);
		while (c == grm_pkg::SPACE_CODE) c = $urandom_range(0, 255);
		return c;
	endfunction

	task automatic send_beat(input grm_pkg::req_t b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_results.push_back(march_result(b));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_write_extremes();
		send_beat(write_beat(0, 0));
		send_beat(write_beat(255, 255));
		send_beat(write_beat(15, grm_pkg::SPACE_CODE));
		send_beat(write_beat(240, 8'h7f));
		send_beat(write_beat(0, grm_pkg::SPACE_CODE));
		send_beat(write_beat(240, grm_pkg::SPACE_CODE));
		send_beat(write_beat(255, grm_pkg::SPACE_CODE));
	endtask

	task automatic test_open_map_casts();
		// diagonal from the corner stays inside for the whole march
		send_beat(cast_beat(0, 0, 90));
		send_beat(cast_beat(0, 0, 0));
		send_beat(cast_beat(0, 0, 360));
		send_beat(cast_beat(65535, 65535, 719));
		send_beat(cast_beat(65535, 65535, 1023));
		send_beat(cast_beat(16'h8800, 16'h8800, 720));
		send_beat(cast_beat(16'h8800, 16'h8800, 900));
	endtask

	task automatic test_wall_hits();
		send_beat(write_beat(8 * 16 + 12, 255));
		send_beat(write_beat(2 * 16 + 8, 0));
		send_beat(write_beat(8 * 16 + 9, 8'h41));
		send_beat(cast_beat(16'h8800, 16'h8800, 0));
		send_beat(cast_beat(16'h8800, 16'h8800, 540));
		send_beat(cast_beat(16'h8000, 16'h8fff, 0));
		send_beat(cast_beat(16'h8800, 16'h8800, 1260 - 720));
		send_beat(write_beat(8 * 16 + 9, grm_pkg::SPACE_CODE));
		send_beat(cast_beat(16'h8800, 16'h8800, 0));
	endtask

	task automatic test_clear_map();
		int i;
		for (i = 0; i < grm_pkg::MAP_CELLS; i++) begin
			send_beat(write_beat(i, grm_pkg::SPACE_CODE));
		end
	endtask

	task automatic test_border_walls();
		int i;
		for (i = 0; i < grm_pkg::MAP_SIDE; i++) begin
			send_beat(write_beat(i, wall_code()));
			send_beat(write_beat((grm_pkg::MAP_SIDE - 1) * grm_pkg::MAP_SIDE + i, wall_code()));
			send_beat(write_beat(i * grm_pkg::MAP_SIDE, wall_code()));
			send_beat(write_beat(i * grm_pkg::MAP_SIDE + grm_pkg::MAP_SIDE - 1, wall_code()));
		end
	endtask

	task automatic test_random_traffic(input int count, input int wall_pct,
		input int write_pct);
		int i;
		int code;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < write_pct) begin
				code = ($urandom_range(0, 99) < wall_pct) ? wall_code() : grm_pkg::SPACE_CODE;
				send_beat(write_beat($urandom_range(0, 255), code));
			end else begin
				send_beat(cast_beat($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 1023)));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_write_extremes();
		test_open_map_casts();
		test_wall_hits();
		wait_drained();
		test_clear_map();
		test_random_traffic(150, 15, 20);
		wait_drained();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_border_walls();
		test_random_traffic(150, 10, 15);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		wait_drained();
		test_random_traffic(200, 60, 35);
		wait_drained();
		test_random_traffic(120, 40, 30);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin : init_map_copy
		int i;
		for (i = 0; i < grm_pkg::MAP_CELLS; i++) map_model[i] = grm_pkg::SPACE_CODE;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 99) < 15) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 3);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		grm_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: result beat with nothing expected, got %h", $time, res);
			end else begin
				want = pending_results.pop_front();
				if (res.status !== want.status || res.step_index !== want.step_index ||
					res.hit_code !== want.hit_code ||
					res.texture_column !== want.texture_column) begin
					fail_count++;
					$display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						$time, want.status, want.step_index, want.hit_code,
						want.texture_column, res.status, res.step_index, res.hit_code,
						res.texture_column);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
